>>> rtl/adc_channel_scan_sequencer_defines.svh
// Assertion macros used by the checker file.
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_DEFINES_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define ACSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ACSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset.
`define ACSS_ASSERT_NXT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/acss_pkg.sv
package acss_pkg;

    // Chain geometry
    localparam int MAX_CHAIN = 16;
    localparam int POS_W     = $clog2(MAX_CHAIN);
    localparam int LEN_W     = 5;
    localparam int CHAN_W    = 3;
    localparam int LIST_W    = 48;
    localparam int SAMPLE_W  = 10;

    // Request type codes
    localparam logic REQ_START     = 1'b0;
    localparam logic REQ_CONV_DONE = 1'b1;

    // Configuration register indexes
    localparam int   CFG_IDX_W        = 1;
    localparam logic CFG_CHAIN_LENGTH = 1'b0;
    localparam logic CFG_CHANNEL_LIST = 1'b1;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0]  CHAIN_LENGTH_RST = 5'd1;
    localparam logic [LIST_W-1:0] CHANNEL_LIST_RST = '0;

    typedef struct packed {
        logic [LEN_W-1:0]  chain_length;
        logic [LIST_W-1:0] channel_list;
    } t_cfg;

    typedef struct packed {
        logic                req_type;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic                start_conv;
        logic [CHAN_W-1:0]   channel_sel;
        logic                store_valid;
        logic [POS_W-1:0]    store_index;
        logic [SAMPLE_W-1:0] store_value;
        logic                chain_done;
        logic                start_rejected;
    } t_out_item;

    // Channel number held in list entry idx
    function automatic logic [CHAN_W-1:0] list_entry(
        input logic [LIST_W-1:0] list,
        input logic [POS_W-1:0]  idx
    );
        logic [CHAN_W-1:0] ch;
        ch = list[CHAN_W*idx +: CHAN_W];
        return ch;
    endfunction

    // Chain length clamped to 1..MAX_CHAIN
    function automatic logic [LEN_W-1:0] effective_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        if (len == '0) begin
            r = LEN_W'(1);
        end else if (len > LEN_W'(MAX_CHAIN)) begin
            r = LEN_W'(MAX_CHAIN);
        end else begin
            r = len;
        end
        return r;
    endfunction

endpackage

>>> rtl/acss_in_if.sv
// Request channel: start requests and conversion-complete events
interface acss_in_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [acss_pkg::SAMPLE_W-1:0]    sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink   (input valid, input req_type, input sample, output ready);
endinterface

>>> rtl/acss_out_if.sv
// Result channel: one result per accepted request
interface acss_out_if;
    logic                             valid;
    logic                             ready;
    logic                             start_conv;
    logic [acss_pkg::CHAN_W-1:0]      channel_sel;
    logic                             store_valid;
    logic [acss_pkg::POS_W-1:0]       store_index;
    logic [acss_pkg::SAMPLE_W-1:0]    store_value;
    logic                             chain_done;
    logic                             start_rejected;

    modport source (output valid, output start_conv, output channel_sel, output store_valid,
                    output store_index, output store_value, output chain_done,
                    output start_rejected, input ready);
    modport sink   (input valid, input start_conv, input channel_sel, input store_valid,
                    input store_index, input store_value, input chain_done,
                    input start_rejected, output ready);
endinterface

>>> rtl/acss_cfg_regs.sv
// Configuration register file, write only
module acss_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [acss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [acss_pkg::LIST_W-1:0]       i_cfg_data,
    output acss_pkg::t_cfg                    o_cfg
);

    acss_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chain_length <= acss_pkg::CHAIN_LENGTH_RST;
            r_cfg.channel_list <= acss_pkg::CHANNEL_LIST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acss_pkg::CFG_CHAIN_LENGTH: begin
                    r_cfg.chain_length <= i_cfg_data[acss_pkg::LEN_W-1:0];
                end
                acss_pkg::CFG_CHANNEL_LIST: begin
                    r_cfg.channel_list <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/acss_in_stage.sv
// Input register: holds one request until the core takes it
module acss_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    acss_in_if.sink             i_in_ch,
    input  logic                i_take,
    output logic                o_valid,
    output acss_pkg::t_in_item  o_item
);

    logic               r_valid;
    acss_pkg::t_in_item r_item;
    logic               w_load;

    // Free when empty or emptied this cycle
    assign i_in_ch.ready = !r_valid || i_take;
    assign w_load        = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.req_type <= i_in_ch.req_type;
            r_item.sample   <= i_in_ch.sample;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/acss_seq_core.sv
// Sequencer state and result register
module acss_seq_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  acss_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  acss_pkg::t_in_item  i_item,
    output logic                o_take,
    acss_out_if.source          o_out_ch
);

    logic                          r_busy;
    logic [acss_pkg::POS_W-1:0]    r_position;
    logic                          r_out_valid;
    acss_pkg::t_out_item           r_out;

    logic                          n_busy;
    logic [acss_pkg::POS_W-1:0]    n_position;
    acss_pkg::t_out_item           n_out;
    logic [acss_pkg::LEN_W-1:0]    w_len;
    logic [acss_pkg::LEN_W-1:0]    w_pos_inc;
    logic [acss_pkg::POS_W-1:0]    w_pos_next;

    // Result register free when empty or being drained
    assign o_take = i_valid && (!r_out_valid || o_out_ch.ready);

    assign w_len      = acss_pkg::effective_length(i_cfg.chain_length);
    assign w_pos_inc  = {1'b0, r_position} + acss_pkg::LEN_W'(1);
    assign w_pos_next = w_pos_inc[acss_pkg::POS_W-1:0];

    // Next state and result for the request in the input register
    always_comb begin
        n_busy     = r_busy;
        n_position = r_position;
        n_out      = '0;
        if (i_item.req_type == acss_pkg::REQ_START) begin
            if (r_busy) begin
                n_out.start_rejected = 1'b1;
            end else begin
                n_busy            = 1'b1;
                n_position        = '0;
                n_out.start_conv  = 1'b1;
                n_out.channel_sel = acss_pkg::list_entry(i_cfg.channel_list, '0);
            end
        end else if (r_busy) begin
            n_out.store_valid = 1'b1;
            n_out.store_index = r_position;
            n_out.store_value = i_item.sample;
            if (w_pos_inc < w_len) begin
                n_position        = w_pos_next;
                n_out.start_conv  = 1'b1;
                n_out.channel_sel = acss_pkg::list_entry(i_cfg.channel_list, w_pos_next);
            end else begin
                n_out.chain_done = 1'b1;
                n_busy           = 1'b0;
                n_position       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_position  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_busy      <= n_busy;
                r_position  <= n_position;
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.start_conv     = r_out.start_conv;
    assign o_out_ch.channel_sel    = r_out.channel_sel;
    assign o_out_ch.store_valid    = r_out.store_valid;
    assign o_out_ch.store_index    = r_out.store_index;
    assign o_out_ch.store_value    = r_out.store_value;
    assign o_out_ch.chain_done     = r_out.chain_done;
    assign o_out_ch.start_rejected = r_out.start_rejected;

endmodule

>>> rtl/adc_channel_scan_sequencer.sv
// ADC channel scan sequencer. Send a start request (req_type 0) to begin a chain: the result
// starts a conversion on list entry 0. Each conversion-complete event (req_type 1) returns a
// store of its sample at the current chain position and either the start of the next listed
// channel or chain_done after chain_length conversions (0 acts as 1, above 16 acts as 16).
// A start while busy gives start_rejected; a completion while idle gives an all-zero result.
// Every accepted request gives exactly one result. A request passes through one input register
// and one result register; one request is accepted every cycle unless the result channel stalls,
// and the result register is refilled in the cycle it is drained. chain_length and channel_list
// are read live on each request; write them only while no request is in flight.
module adc_channel_scan_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [acss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [acss_pkg::LIST_W-1:0]       i_cfg_data,
    acss_in_if.sink                           i_in_ch,
    acss_out_if.source                        o_out_ch
);

    acss_pkg::t_cfg     w_cfg;
    logic               w_in_valid;
    acss_pkg::t_in_item w_in_item;
    logic               w_take;

    // Configuration registers
    acss_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Input register
    acss_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (i_in_ch),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    // Sequencer and result register
    acss_seq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_in_valid),
        .i_item   (w_in_item),
        .o_take   (w_take),
        .o_out_ch (o_out_ch)
    );

endmodule

>>> rtl/acss_checker.sv
`include "adc_channel_scan_sequencer_defines.svh"

// Port-level checks on the result channel
module acss_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_start_conv,
    input  logic                              i_store_valid,
    input  logic [acss_pkg::POS_W-1:0]        i_store_index,
    input  logic [acss_pkg::SAMPLE_W-1:0]     i_store_value,
    input  logic                              i_chain_done,
    input  logic                              i_start_rejected
);

    // Reset empties the result register
    `ACSS_ASSERT_NXT_RST(a_rst_empty, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

    // A stalled result holds its store fields
    `ACSS_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_store_index) && $stable(i_store_value), "stalled result changed")

    // Chain end stores a sample and starts nothing
    `ACSS_ASSERT_IMP(a_done_store, i_clk, i_rst_n, i_out_valid && i_chain_done, i_store_valid && !i_start_conv, "chain_done without store")

    // Rejected start leaves the chain alone
    `ACSS_ASSERT_IMP(a_reject_quiet, i_clk, i_rst_n, i_out_valid && i_start_rejected, !i_start_conv && !i_store_valid && !i_chain_done, "rejected start did work")

endmodule

bind adc_channel_scan_sequencer acss_checker u_acss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out_ch.valid),
    .i_out_ready      (o_out_ch.ready),
    .i_start_conv     (o_out_ch.start_conv),
    .i_store_valid    (o_out_ch.store_valid),
    .i_store_index    (o_out_ch.store_index),
    .i_store_value    (o_out_ch.store_value),
    .i_chain_done     (o_out_ch.chain_done),
    .i_start_rejected (o_out_ch.start_rejected)
);

>>> test/testbench.sv
module testbench;
    import acss_pkg::*;

    localparam int TOTAL_ITEMS    = 1950;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 200;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LIST_W-1:0]    i_cfg_data;

    acss_in_if  in_ch();
    acss_out_if out_ch();

    adc_channel_scan_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    // requests waiting to be sent, and results owed by the sequencer
    t_in_item  scan_requests[$];
    t_out_item scan_results_due[$];
    int        items_queued = 0;

    // shadow copy of the registers and the chain state
    logic [LEN_W-1:0]  cfg_chain_length = CHAIN_LENGTH_RST;
    logic [LIST_W-1:0] cfg_channel_list = CHANNEL_LIST_RST;
    logic              scan_busy        = 1'b0;
    logic [POS_W-1:0]  scan_pos         = '0;

    // idle burst chance in percent, shared by both sides
    int idle_pct = 0;

    // receiver hold-off request: toggled by the stimulus, taken by the hold counter
    logic rx_hold_req = 1'b0;
    logic rx_hold_ack;
    int   rx_hold_left;

    int error_count = 0;
    int result_count = 0;
    int cycle_count = 0;

    // next chain step for one accepted request; updates the shadow chain state
    function automatic t_out_item next_scan_result(input t_in_item req);
        t_out_item r;
        int        eff_len;
        r = '0;
        if (req.req_type == REQ_START) begin
            if (scan_busy) begin
                r.start_rejected = 1'b1;
            end else begin
                scan_busy     = 1'b1;
                scan_pos      = '0;
                r.start_conv  = 1'b1;
                r.channel_sel = cfg_channel_list[CHAN_W-1:0];
            end
        end else if (scan_busy) begin
            eff_len = int'(cfg_chain_length);
            if (eff_len == 0) eff_len = 1;
            if (eff_len > MAX_CHAIN) eff_len = MAX_CHAIN;
            r.store_valid = 1'b1;
            r.store_index = scan_pos;
            r.store_value = req.sample;
            if (int'(scan_pos) + 1 < eff_len) begin
                scan_pos      = scan_pos + 1'b1;
                r.start_conv  = 1'b1;
                r.channel_sel = cfg_channel_list[CHAN_W*scan_pos +: CHAN_W];
            end else begin
                r.chain_done = 1'b1;
                scan_busy    = 1'b0;
                scan_pos     = '0;
            end
        end
        return r;
    endfunction

    function automatic void queue_request(input logic rtype, input logic [SAMPLE_W-1:0] s);
        t_in_item it;
        it.req_type = rtype;
        it.sample   = s;
        scan_requests.push_back(it);
        items_queued++;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (error_count < MAX_REPORTS)
            $display("mismatch in result %0d, %s: got %0d, want %0d",
                     result_count, field, got, want);
        error_count++;
    endtask

    // register write at one clock edge; shadow copy follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIST_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_CHAIN_LENGTH) cfg_chain_length = val[LEN_W-1:0];
        else cfg_channel_list = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every request is sent and every result is back, then let the pipe settle;
    // polled mid-cycle so the driver's updates at the edge are already visible
    task automatic drain_and_settle();
        do @(negedge i_clk);
        while (scan_requests.size() != 0 || in_ch.valid || scan_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // request driver: offers the queue head, predicts on each transfer
    int       tx_gap;
    t_in_item tx_item;
    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            tx_gap      <= 0;
        end else begin
            offer = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                scan_results_due.push_back(next_scan_result(tx_item));
                offer = 1'b0;
            end
            if (!offer) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                    tx_gap <= $urandom_range(12, 0);
                end else if (scan_requests.size() != 0) begin
                    tx_item = scan_requests.pop_front();
                    offer   = 1'b1;
                end
            end
            in_ch.valid    <= offer;
            in_ch.req_type <= tx_item.req_type;
            in_ch.sample   <= tx_item.sample;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_ack  <= 1'b0;
            rx_hold_left <= 0;
        end else if (rx_hold_ack != rx_hold_req) begin
            rx_hold_ack  <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // result monitor: checks each transfer against the oldest prediction, drives ready
    int rx_gap;
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_gap       <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (scan_results_due.size() == 0) begin
                    report_mismatch("result with none pending", 1, 0);
                end else begin
                    want = scan_results_due.pop_front();
                    if (out_ch.start_conv !== want.start_conv)
                        report_mismatch("start_conv", out_ch.start_conv, want.start_conv);
                    if (out_ch.channel_sel !== want.channel_sel)
                        report_mismatch("channel_sel", out_ch.channel_sel, want.channel_sel);
                    if (out_ch.store_valid !== want.store_valid)
                        report_mismatch("store_valid", out_ch.store_valid, want.store_valid);
                    if (out_ch.store_index !== want.store_index)
                        report_mismatch("store_index", out_ch.store_index, want.store_index);
                    if (out_ch.store_value !== want.store_value)
                        report_mismatch("store_value", out_ch.store_value, want.store_value);
                    if (out_ch.chain_done !== want.chain_done)
                        report_mismatch("chain_done", out_ch.chain_done, want.chain_done);
                    if (out_ch.start_rejected !== want.start_rejected)
                        report_mismatch("start_rejected", out_ch.start_rejected,
                                        want.start_rejected);
                end
                result_count++;
            end
            if (rx_hold_left != 0) begin
                out_ch.ready <= 1'b0;
            end else if (rx_gap != 0) begin
                out_ch.ready <= 1'b0;
                rx_gap       <= rx_gap - 1;
            end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                out_ch.ready <= 1'b0;
                rx_gap       <= $urandom_range(12, 0);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        logic [LIST_W-1:0] list;
        int                len;
        int                eff;
        int                r;
        int                n;
        int                target;
        int                phase;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_CHAIN_LENGTH;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.req_type = REQ_START;
        in_ch.sample   = '0;
        out_ch.ready   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // completion while idle, then a one-entry chain on reset settings
        idle_pct = 20;
        queue_request(REQ_CONV_DONE, '1);
        queue_request(REQ_START, '0);
        queue_request(REQ_CONV_DONE, 10'h155);
        drain_and_settle();

        // every list entry distinct per half; length above the maximum saturates
        list = '0;
        for (int k = 0; k < MAX_CHAIN; k++)
            list[CHAN_W*k +: CHAN_W] = CHAN_W'(k < 8 ? k : 15 - k);
        write_reg(CFG_CHANNEL_LIST, list);
        write_reg(CFG_CHAIN_LENGTH, LIST_W'(31));
        queue_request(REQ_START, '1);
        for (int k = 0; k < 8; k++)
            queue_request(REQ_CONV_DONE, (k % 2) ? '1 : '0);
        // start while busy is refused and leaves the chain alone
        queue_request(REQ_START, '0);
        for (int k = 0; k < 8; k++)
            queue_request(REQ_CONV_DONE, SAMPLE_W'($urandom_range(1023)));
        drain_and_settle();

        // length cut to zero mid-chain: next stored sample ends the chain
        write_reg(CFG_CHAIN_LENGTH, LIST_W'(5));
        queue_request(REQ_START, '0);
        queue_request(REQ_CONV_DONE, 10'h2AA);
        queue_request(REQ_CONV_DONE, 10'h155);
        drain_and_settle();
        write_reg(CFG_CHAIN_LENGTH, LIST_W'(0));
        queue_request(REQ_CONV_DONE, 10'h3C3);
        queue_request(REQ_START, '0);
        queue_request(REQ_CONV_DONE, 10'h03C);
        drain_and_settle();

        // random phases, fresh settings each
        phase = 0;
        while (items_queued < TOTAL_ITEMS) begin
            r = $urandom_range(4);
            len = (r == 0) ? 0 : (r == 1) ? 31 : (r == 2) ? MAX_CHAIN :
                  (r == 3) ? 1 : $urandom_range(31);
            write_reg(CFG_CHAIN_LENGTH, LIST_W'(len));
            write_reg(CFG_CHANNEL_LIST, LIST_W'({$urandom, $urandom}));
            eff = (len == 0) ? 1 : (len > MAX_CHAIN) ? MAX_CHAIN : len;

            if (items_queued > TOTAL_ITEMS - 250) idle_pct = 0;
            else if (phase % 3 == 0) idle_pct = 0;
            else if (phase % 3 == 1) idle_pct = 10;
            else idle_pct = 35;

            // receiver holds off while the sender keeps offering
            if (phase == 2) begin
                idle_pct = 0;
                rx_hold_req <= ~rx_hold_req;
            end

            n = $urandom_range(40, 120);
            target = items_queued + n;
            while (items_queued < target) begin
                r = $urandom_range(99);
                if (r < 75) begin
                    queue_request(REQ_START, SAMPLE_W'($urandom_range(1023)));
                    for (int k = 0; k < eff; k++) begin
                        if ($urandom_range(19) == 0)
                            queue_request(REQ_START, SAMPLE_W'($urandom_range(1023)));
                        queue_request(REQ_CONV_DONE, SAMPLE_W'($urandom_range(1023)));
                    end
                end else if (r < 85) begin
                    queue_request(REQ_CONV_DONE, SAMPLE_W'($urandom_range(1023)));
                end else if (r < 92) begin
                    queue_request(REQ_START, SAMPLE_W'($urandom_range(1023)));
                end else begin
                    // broken chain, left running
                    queue_request(REQ_START, SAMPLE_W'($urandom_range(1023)));
                    for (int k = 0; k < $urandom_range(eff - 1); k++)
                        queue_request(REQ_CONV_DONE, SAMPLE_W'($urandom_range(1023)));
                end
            end
            drain_and_settle();
            phase++;
        end

        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
